FILE: hw/rtl/tct_pkg.sv
// Shared types, widths and helpers for the tolerant color table.
package tct_pkg;

    localparam int CH_W       = 10;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int K_W        = 10;
    localparam int CHAN_MAX   = 1000;
    localparam int TABLE_SIZE_DEF = 256;
    localparam int BASE_TOL_DEF   = 16;
    localparam int TOL_STEP_DEF   = 8;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    localparam color_t COLOR_BLACK = '{red: '0, green: '0, blue: '0};
    localparam color_t COLOR_WHITE = '{red: CH_W'(CHAN_MAX), green: CH_W'(CHAN_MAX),
                                       blue: CH_W'(CHAN_MAX)};

    // Query moving down the chain
    typedef struct packed {
        logic   valid;
        color_t color;
    } query_t;

    // Running search result moving down the chain
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             best_valid;
        logic [K_W-1:0]   best_k;
        logic [IDX_W-1:0] best_idx;
    } scan_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: hw/rtl/tct_cell.sv
// One palette entry with its distance stage and search-merge stage.
module tct_cell
    import tct_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int BASE_TOL = BASE_TOL_DEF,
    parameter int TOL_STEP = TOL_STEP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  query_t           q_in,
    input  scan_t            scan_in,
    input  logic [CH_W-1:0]  tol,
    input  logic [CNT_W-1:0] count,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  color_t           wr_color,
    output query_t           q_out,
    output scan_t            scan_out
);

    // Widened-step index k = ceil((d - BASE_TOL) / TOL_STEP) by reciprocal multiply
    localparam int Y_W  = 11;
    localparam int SH   = Y_W + $clog2(TOL_STEP);
    localparam int RECIP = ((2 ** SH) + TOL_STEP - 1) / TOL_STEP;
    localparam int PW   = SH + Y_W + 1;
    localparam int DMAX = BASE_TOL + ((CHAN_MAX - BASE_TOL) / TOL_STEP) * TOL_STEP;

    color_t          entry_reg;
    query_t          q_reg;
    logic [CH_W-1:0] dist_reg;
    logic [CH_W-1:0] dist_next;
    scan_t           scan_reg;
    scan_t           scan_next;
    logic            active;
    logic            in_range;
    logic [Y_W-1:0]  y;
    logic [PW-1:0]   prod;
    logic [K_W-1:0]  k;
    logic [CH_W-1:0] dr;
    logic [CH_W-1:0] dg;
    logic [CH_W-1:0] db;

    // Worst channel distance between the passing query and this entry
    always_comb
    begin
        dr = abs_diff(q_in.color.red, entry_reg.red);
        dg = abs_diff(q_in.color.green, entry_reg.green);
        db = abs_diff(q_in.color.blue, entry_reg.blue);
        dist_next = dr;
        if (dg > dist_next)
        begin
            dist_next = dg;
        end
        if (db > dist_next)
        begin
            dist_next = db;
        end
    end

    assign active   = (count > CNT_W'(IDX));
    assign in_range = (dist_reg <= CH_W'(DMAX));
    assign y        = Y_W'(dist_reg) - Y_W'(BASE_TOL) + Y_W'(TOL_STEP - 1);
    assign prod     = PW'(y) * PW'(RECIP);

    always_comb
    begin
        if (dist_reg <= CH_W'(BASE_TOL))
        begin
            k = '0;
        end
        else
        begin
            k = prod[SH +: K_W];
        end
    end

    // Merge this entry into the running search result
    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.valid && active)
        begin
            if (!scan_in.found && (dist_reg <= tol))
            begin
                scan_next.found     = 1'b1;
                scan_next.found_idx = IDX_W'(IDX);
            end
            if (in_range && (!scan_in.best_valid || (k < scan_in.best_k)))
            begin
                scan_next.best_valid = 1'b1;
                scan_next.best_k     = k;
                scan_next.best_idx   = IDX_W'(IDX);
            end
        end
    end

    // Hold the entry, advance query and search result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= (IDX == 1) ? COLOR_WHITE : COLOR_BLACK;
            q_reg     <= '0;
            dist_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            if (wr_en && (wr_idx == IDX_W'(IDX)))
            begin
                entry_reg <= wr_color;
            end
            q_reg    <= q_in;
            dist_reg <= dist_next;
            scan_reg <= scan_next;
        end
    end

    assign q_out    = q_reg;
    assign scan_out = scan_reg;

endmodule

FILE: hw/rtl/tolerant_color_table_top.sv
// A lookup is launched into the row of entry cells, decided in the scan state and
// held in the done state until the output is free; a flush goes straight to the done
// state. Input stalls outside idle. The query walks the entry cells one per cycle.
// A new item is taken while a finished result still waits at the output.
// Reset: palette holds black at index 0 and white at index 1, two entries in use,
// tolerance 16; no clearing pass.
module tolerant_color_table_top
    import tct_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int BASE_TOL   = BASE_TOL_DEF,
    parameter int TOL_STEP   = TOL_STEP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CH_W-1:0]   cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  color_index,
    output logic              was_added,
    output logic              by_nearest
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg,       state_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [CH_W-1:0]   tol_reg,         tol_next;
    color_t            color_reg,       color_next;
    query_t            launch_q_reg,    launch_q_next;
    scan_t             launch_s_reg,    launch_s_next;
    logic [IDX_W-1:0]  pend_idx_reg,    pend_idx_next;
    logic              pend_added_reg,  pend_added_next;
    logic              pend_near_reg,   pend_near_next;
    logic              out_valid_reg,   out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg,     out_idx_next;
    logic              out_added_reg,   out_added_next;
    logic              out_near_reg,    out_near_next;

    logic              in_xfer;
    logic              out_free;
    logic              wr_en;
    scan_t             scan_done;

    query_t            q_chain [0:TABLE_SIZE];
    scan_t             s_chain [0:TABLE_SIZE];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Row of entry cells
    assign q_chain[0] = launch_q_reg;
    assign s_chain[0] = launch_s_reg;

    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_cell
        tct_cell #(
            .IDX      (i),
            .BASE_TOL (BASE_TOL),
            .TOL_STEP (TOL_STEP)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .q_in     (q_chain[i]),
            .scan_in  (s_chain[i]),
            .tol      (tol_reg),
            .count    (entry_count_reg),
            .wr_en    (wr_en),
            .wr_idx   (entry_count_reg[IDX_W-1:0]),
            .wr_color (color_reg),
            .q_out    (q_chain[i+1]),
            .scan_out (s_chain[i+1])
        );
    end

    assign scan_done = s_chain[TABLE_SIZE];
    assign wr_en     = (state_reg == ST_SCAN) && scan_done.valid && !scan_done.found
                       && (entry_count_reg < CNT_W'(TABLE_SIZE));

    // Sequencer: launch, decide, deliver
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        tol_next         = cfg_wr_en ? cfg_wr_data : tol_reg;
        color_next       = color_reg;
        launch_q_next    = '0;
        launch_s_next    = '0;
        launch_s_next.valid = launch_q_reg.valid;
        pend_idx_next    = pend_idx_reg;
        pend_added_next  = pend_added_reg;
        pend_near_next   = pend_near_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_idx_next     = out_idx_reg;
        out_added_next   = out_added_reg;
        out_near_next    = out_near_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (func)
                    begin
                        entry_count_next = CNT_W'(2);
                        pend_idx_next    = '0;
                        pend_added_next  = 1'b0;
                        pend_near_next   = 1'b0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        color_next          = '{red: red, green: green, blue: blue};
                        launch_q_next.valid = 1'b1;
                        launch_q_next.color = '{red: red, green: green, blue: blue};
                        state_next          = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done.valid)
                begin
                    pend_added_next = 1'b0;
                    pend_near_next  = 1'b0;
                    if (scan_done.found)
                    begin
                        pend_idx_next = scan_done.found_idx;
                    end
                    else if (wr_en)
                    begin
                        pend_idx_next    = entry_count_reg[IDX_W-1:0];
                        pend_added_next  = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pend_near_next = 1'b1;
                        pend_idx_next  = scan_done.best_valid ? scan_done.best_idx : '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = pend_idx_reg;
                    out_added_next = pend_added_reg;
                    out_near_next  = pend_near_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= CNT_W'(2);
            tol_reg         <= CH_W'(16);
            launch_q_reg    <= '0;
            launch_s_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            tol_reg         <= tol_next;
            launch_q_reg    <= launch_q_next;
            launch_s_reg    <= launch_s_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        color_reg      <= color_next;
        pend_idx_reg   <= pend_idx_next;
        pend_added_reg <= pend_added_next;
        pend_near_reg  <= pend_near_next;
        out_idx_reg    <= out_idx_next;
        out_added_reg  <= out_added_next;
        out_near_reg   <= out_near_next;
    end

    assign out_valid   = out_valid_reg;
    assign color_index = out_idx_reg;
    assign was_added   = out_added_reg;
    assign by_nearest  = out_near_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count_reg >= CNT_W'(2)) && (entry_count_reg <= CNT_W'(TABLE_SIZE)))
        else $error("entry count out of range");

    a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done.valid |-> (state_reg == ST_SCAN))
        else $error("search result arrived outside a scan");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_added && by_nearest))
        else $error("append and widened search flagged together");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (entry_count_reg == $past(entry_count_reg) + CNT_W'(1)))
        else $error("append did not advance the entry count");
`endif

endmodule

FILE: tb/sv/tolerant_color_table_checker.sv
// Transfer monitor, palette predictor and result comparison for the tolerant color table.
`timescale 1ns / 1ps

module tolerant_color_table_checker
    import tct_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int BASE_TOL   = BASE_TOL_DEF,
    parameter int TOL_STEP   = TOL_STEP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CH_W-1:0]  cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             func,
    input  logic [CH_W-1:0]  red,
    input  logic [CH_W-1:0]  green,
    input  logic [CH_W-1:0]  blue,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [IDX_W-1:0] color_index,
    input  logic             was_added,
    input  logic             by_nearest,
    output int               pending,
    output int               fail_count
);

    localparam int TOL_RESET  = 16;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [IDX_W-1:0] color_index;
        logic             was_added;
        logic             by_nearest;
    } lookup_result_t;

    color_t          palette_mem [TABLE_SIZE];
    int              entry_cnt;
    logic [CH_W-1:0] tolerance;
    lookup_result_t  expected_q [$];

    // Restore black and white as the only entries
    function automatic void clear_palette();
        int i;
        for (i = 0; i < TABLE_SIZE; i++)
            palette_mem[i] = COLOR_BLACK;
        palette_mem[1] = COLOR_WHITE;
        entry_cnt = 2;
    endfunction

    function automatic int chan_gap(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Largest per-channel distance between an entry and the query
    function automatic int color_gap(input color_t e, input color_t c);
        int d, dg, db;
        d  = chan_gap(e.red, c.red);
        dg = chan_gap(e.green, c.green);
        db = chan_gap(e.blue, c.blue);
        if (dg > d)
            d = dg;
        if (db > d)
            d = db;
        return d;
    endfunction

    // Work out the result of one transfer and advance the palette copy
    function automatic lookup_result_t predict_color(input logic flush_req, input color_t c);
        lookup_result_t res;
        int             i, d, k, best_k;
        bit             hit, near_hit;
        res      = '0;
        hit      = 1'b0;
        near_hit = 1'b0;
        best_k   = 0;
        if (flush_req)
        begin
            clear_palette();
            return res;
        end
        // Take the lowest entry within the configured tolerance
        for (i = 0; i < entry_cnt && !hit; i++)
        begin
            if (color_gap(palette_mem[i], c) <= int'(tolerance))
            begin
                res.color_index = IDX_W'(i);
                hit = 1'b1;
            end
        end
        if (hit)
            return res;
        // Append while there is room
        if (entry_cnt < TABLE_SIZE)
        begin
            palette_mem[entry_cnt] = c;
            res.color_index = IDX_W'(entry_cnt);
            res.was_added   = 1'b1;
            entry_cnt++;
            return res;
        end
        // Widen in steps; the fewest steps win, then the lowest index
        res.by_nearest = 1'b1;
        for (i = 0; i < entry_cnt; i++)
        begin
            d = color_gap(palette_mem[i], c);
            k = (d <= BASE_TOL) ? 0 : (d - BASE_TOL + TOL_STEP - 1) / TOL_STEP;
            if (BASE_TOL + k * TOL_STEP <= CHAN_MAX && (!near_hit || k < best_k))
            begin
                best_k          = k;
                res.color_index = IDX_W'(i);
                near_hit        = 1'b1;
            end
        end
        return res;
    endfunction

    // Track configuration, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin : track_transfers
        lookup_result_t exp_res;
        bit             in_fire, out_fire;
        if (!rst_n)
        begin
            clear_palette();
            tolerance = CH_W'(TOL_RESET);
            expected_q.delete();
            pending    <= 0;
            fail_count = 0;
        end
        else
        begin
            in_fire  = in_valid && !in_stall;
            out_fire = out_valid && !out_stall;
            if (cfg_wr_en)
                tolerance = cfg_wr_data;
            if (out_fire)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("[%0t] result with none expected: idx %0d added %0b nearest %0b",
                                 $time, color_index, was_added, by_nearest);
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (color_index !== exp_res.color_index ||
                        was_added !== exp_res.was_added ||
                        by_nearest !== exp_res.by_nearest)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT)
                            $display("[%0t] mismatch idx %0d/%0d added %0b/%0b nearest %0b/%0b (exp/got)",
                                     $time, exp_res.color_index, color_index,
                                     exp_res.was_added, was_added,
                                     exp_res.by_nearest, by_nearest);
                    end
                end
            end
            if (in_fire)
            begin
                exp_res    = predict_color(func, '{red: red, green: green, blue: blue});
                expected_q = {expected_q, exp_res};
            end
            pending <= pending + int'(in_fire) - int'(out_fire);
        end
    end

endmodule

FILE: tb/sv/tolerant_color_table_top_tb.sv
// Stimulus, reset, watchdog and verdict for the tolerant color table testbench.
`timescale 1ns / 1ps

module tolerant_color_table_top_tb;
    import tct_pkg::*;

    localparam int   TABLE_SIZE   = TABLE_SIZE_DEF;
    localparam int   BASE_TOL     = BASE_TOL_DEF;
    localparam int   TOL_STEP     = TOL_STEP_DEF;
    localparam int   QUIET_LIMIT  = 5000;
    localparam int   DRAIN_CYCLES = TABLE_SIZE + 40;
    localparam int   NUM_PHASES   = 8;
    localparam int   CH_TOP       = (1 << CH_W) - 1;
    localparam int   SPAN_MAX     = 40;
    localparam logic FUNC_LOOKUP  = 1'b0;
    localparam logic FUNC_FLUSH   = 1'b1;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CH_W-1:0]  cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             func        = FUNC_LOOKUP;
    logic [CH_W-1:0]  red         = '0;
    logic [CH_W-1:0]  green       = '0;
    logic [CH_W-1:0]  blue        = '0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [IDX_W-1:0] color_index;
    logic             was_added;
    logic             by_nearest;
    int               pending;
    int               fail_count;

    int     burst_left   = 0;
    int     quiet_cycles = 0;
    int     stall_mode   = 0;
    int     mode_timer   = 0;
    int     stall_run    = 0;
    color_t sent_q [$];

    // Per phase: tolerance, item count, flush chance in percent
    int phase_tol   [NUM_PHASES] = '{0, 1000, 5, 1023, 0, 16, 40, 1};
    int phase_items [NUM_PHASES] = '{420, 150, 250, 100, 200, 300, 200, 260};
    int phase_flush [NUM_PHASES] = '{0, 2, 0, 3, 1, 0, 2, 0};

    tolerant_color_table_top #(
        .TABLE_SIZE (TABLE_SIZE),
        .BASE_TOL   (BASE_TOL),
        .TOL_STEP   (TOL_STEP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index),
        .was_added   (was_added),
        .by_nearest  (by_nearest)
    );

    tolerant_color_table_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .BASE_TOL   (BASE_TOL),
        .TOL_STEP   (TOL_STEP)
    ) palette_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index),
        .was_added   (was_added),
        .by_nearest  (by_nearest),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the output: free-running, random, or long on/off runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            mode_timer <= 0;
            stall_run  <= 0;
        end
        else
        begin
            if (mode_timer == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_timer <= $urandom_range(500, 3000);
            end
            else
                mode_timer <= mode_timer - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_run == 0)
                    begin
                        out_stall <= !out_stall;
                        stall_run <= $urandom_range(1, 40);
                    end
                    else
                        stall_run <= stall_run - 1;
                end
            endcase
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [CH_W-1:0] corner_chan();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CH_W'(1);
            2:       return CH_W'(CHAN_MAX - 1);
            3:       return CH_W'(CHAN_MAX);
            4:       return CH_W'(CHAN_MAX + 1);
            default: return '1;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_chan();
        if ($urandom_range(0, 7) == 0)
            return corner_chan();
        return CH_W'($urandom_range(0, CH_TOP));
    endfunction

    // Move a channel by up to span either way, clipped to the field range
    function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] v, input int span);
        int x;
        x = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (x < 0)
            x = 0;
        if (x > CH_TOP)
            x = CH_TOP;
        return CH_W'(x);
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 0;
        if (sel < 8)
            return $urandom_range(1, 4);
        if (sel < 9)
            return $urandom_range(5, 60);
        return $urandom_range(100, 320);
    endfunction

    // Present one item in bursts with gaps, hold it until the transfer
    task automatic send_item(input logic f, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = pick_gap();
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        func     <= f;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_tolerance(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CH_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly fresh and near-repeat colors, some corner colors and flushes
    task automatic run_random(input int count, input int flush_pct, input int span);
        int     n, sel;
        color_t c, base;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < flush_pct)
            begin
                send_item(FUNC_FLUSH, pick_chan(), pick_chan(), pick_chan());
                sent_q.delete();
            end
            else
            begin
                if (sel < 55 || sent_q.size() == 0)
                    c = '{red: pick_chan(), green: pick_chan(), blue: pick_chan()};
                else if (sel < 88)
                begin
                    base = sent_q[$urandom_range(0, sent_q.size() - 1)];
                    c = '{red: nudge(base.red, span), green: nudge(base.green, span),
                          blue: nudge(base.blue, span)};
                end
                else
                    c = '{red: corner_chan(), green: corner_chan(), blue: corner_chan()};
                send_item(FUNC_LOOKUP, c.red, c.green, c.blue);
                sent_q = {sent_q, c};
                if (sent_q.size() > TABLE_SIZE)
                    void'(sent_q.pop_front());
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int p, span;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset tolerance
        send_item(FUNC_LOOKUP, '0, '0, '0);
        send_item(FUNC_LOOKUP, CH_W'(CHAN_MAX), CH_W'(CHAN_MAX), CH_W'(CHAN_MAX));
        send_item(FUNC_LOOKUP, '1, '1, '1);
        send_item(FUNC_LOOKUP, CH_W'(1000), CH_W'(0), CH_W'(500));
        // hit exactly on the tolerance edge, then one past it
        send_item(FUNC_LOOKUP, CH_W'(1016), CH_W'(16), CH_W'(516));
        send_item(FUNC_LOOKUP, CH_W'(1017), CH_W'(16), CH_W'(516));
        send_item(FUNC_LOOKUP, CH_W'(16), CH_W'(16), CH_W'(16));
        send_item(FUNC_LOOKUP, CH_W'(17), CH_W'(0), CH_W'(0));
        send_item(FUNC_LOOKUP, '0, '1, '0);
        send_item(FUNC_LOOKUP, '0, '0, '1);
        send_item(FUNC_LOOKUP, '1, '0, '0);
        send_item(FUNC_LOOKUP, CH_W'(512), CH_W'(512), CH_W'(512));
        send_item(FUNC_LOOKUP, CH_W'(341), CH_W'(682), CH_W'(1001));
        send_item(FUNC_FLUSH, '1, '1, '1);
        // entries past white must be gone after the flush
        send_item(FUNC_LOOKUP, '1, '1, '1);
        send_item(FUNC_LOOKUP, CH_W'(1000), CH_W'(0), CH_W'(500));
        send_item(FUNC_LOOKUP, CH_W'(984), CH_W'(984), CH_W'(984));
        send_item(FUNC_FLUSH, '0, '0, '0);
        send_item(FUNC_FLUSH, CH_W'(682), CH_W'(341), CH_W'(22));
        send_item(FUNC_LOOKUP, CH_W'(8), CH_W'(8), CH_W'(8));
        in_valid <= 1'b0;
        wait_idle();

        // Random phases, each under its own tolerance
        phase_tol[4] = $urandom_range(0, CH_TOP);
        for (p = 0; p < NUM_PHASES; p++)
        begin
            span = (phase_tol[p] < SPAN_MAX) ? phase_tol[p] + 2 : SPAN_MAX;
            write_tolerance(phase_tol[p]);
            run_random(phase_items[p], phase_flush[p], span);
            wait_idle();
        end

        // Drain and give the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
